### src/audio_distortion_waveshaper_core_macros.svh
// Assertion macros for the waveshaper core checker.
// No dependencies; included by files that assert.
`ifndef AUDIO_DISTORTION_WAVESHAPER_CORE_MACROS_SVH
`define AUDIO_DISTORTION_WAVESHAPER_CORE_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ADWV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ADWV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/adwv_pkg.sv
// Shared widths, register codes, config struct and exp lookup tables.
// No dependencies; imported by every module of the waveshaper core.
package adwv_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int FRAC_BITS      = SAMPLE_BITS - 1;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 12;
   localparam int LEVEL_BITS     = 23;
   localparam int RECIP_BITS     = 32;
   localparam int RECIP_FRAC     = 16;
   localparam int MODE_BITS      = 3;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 32;

   // drive product, driven value and its magnitude
   localparam int DPROD_BITS     = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int DRV_BITS       = SAMPLE_BITS + GAIN_BITS - GAIN_FRAC;
   localparam int MAG_BITS       = DRV_BITS - 1;
   localparam int ONE_BITS       = FRAC_BITS + 1;
   localparam int T_BITS         = RECIP_BITS + FRAC_BITS - RECIP_FRAC;
   localparam int OPROD_BITS     = DRV_BITS + GAIN_BITS + 1;
   localparam int ORND_BITS      = OPROD_BITS - GAIN_FRAC;

   // exp table: exp(-x) sampled over [0, 2^EXP_RANGE_LOG2), Q1.30
   localparam int EXP_TABLE_ENTRIES = 256;
   localparam int EXP_IDX_BITS      = $clog2(EXP_TABLE_ENTRIES);
   localparam int EXP_RANGE_LOG2    = 4;
   localparam int EXP_S_BITS        = MAG_BITS + EXP_IDX_BITS;
   localparam int EXP_FR_BITS       = 16;
   localparam int EXP_Q             = 30;
   localparam int EXP_TERMS         = 20;

   // accept to strobe
   localparam int PIPE_LATENCY   = 10;

   localparam logic [ONE_BITS-1:0]   ONE_Q    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [MAG_BITS-1:0]   HALF_MAG = MAG_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [EXP_Q:0]        EXP_ONE  = {1'b1, {EXP_Q{1'b0}}};
   localparam logic [DPROD_BITS-1:0] DRV_HALF = DPROD_BITS'(1) << (GAIN_FRAC - 1);
   localparam logic [OPROD_BITS-1:0] OUT_HALF = OPROD_BITS'(1) << (GAIN_FRAC - 1);

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE   = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_DRIVE  = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUTPUT = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEVEL  = CSR_IDX_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECIP  = CSR_IDX_BITS'(4);

   typedef enum logic [MODE_BITS-1:0] {
      MODE_HARD,
      MODE_SOFT,
      MODE_EXP,
      MODE_FULL,
      MODE_HALF
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [GAIN_BITS-1:0]    drive_gain;
      logic [GAIN_BITS-1:0]    output_gain;
      logic [LEVEL_BITS-1:0]   clip_level;
      logic [RECIP_BITS-1:0]   clip_recip;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:        MODE_HARD,
      drive_gain:  16'd2048,
      output_gain: 16'd410,
      clip_level:  23'h7FFFFF,
      clip_recip:  32'd131072
   };

   typedef struct packed {
      logic valid;
      logic block_end;
   } tag_type;

   typedef logic [63:0]      exp_full_type [EXP_TABLE_ENTRIES + 1];
   typedef logic [EXP_Q:0]   exp_base_type [EXP_TABLE_ENTRIES];
   typedef logic [EXP_Q-1:0] exp_diff_type [EXP_TABLE_ENTRIES];

   // step ratio exp(-h) by truncated series, then powers of it
   function automatic exp_full_type exp_full_table();
      exp_full_type tab;
      logic [63:0]  h;
      logic [63:0]  t;
      logic [63:0]  q;
      int           i;
      h = (64'd1 << (EXP_Q + EXP_RANGE_LOG2)) / EXP_TABLE_ENTRIES;
      t = 64'd1 << EXP_Q;
      q = t;
      for (i = 1; i <= EXP_TERMS; i++) begin
         t = ((t * h) >> EXP_Q) / 64'(i);
         if (i[0]) begin
            q = q - t;
         end else begin
            q = q + t;
         end
      end
      tab[0] = 64'd1 << EXP_Q;
      for (i = 1; i <= EXP_TABLE_ENTRIES; i++) begin
         tab[i] = (tab[i-1] * q) >> EXP_Q;
      end
      return tab;
   endfunction

   localparam exp_full_type EXP_FULL = exp_full_table();

   function automatic exp_base_type exp_base_table();
      exp_base_type b;
      int           k;
      for (k = 0; k < EXP_TABLE_ENTRIES; k++) begin
         b[k] = EXP_FULL[k][EXP_Q:0];
      end
      return b;
   endfunction

   function automatic exp_diff_type exp_diff_table();
      exp_diff_type d;
      logic [63:0]  w;
      int           k;
      for (k = 0; k < EXP_TABLE_ENTRIES; k++) begin
         w    = EXP_FULL[k] - EXP_FULL[k+1];
         d[k] = w[EXP_Q-1:0];
      end
      return d;
   endfunction

   localparam exp_base_type   EXP_BASE = exp_base_table();
   localparam exp_diff_type   EXP_DIFF = exp_diff_table();
   localparam logic [EXP_Q:0] EXP_LAST = EXP_FULL[EXP_TABLE_ENTRIES][EXP_Q:0];

   // Q0.23 level to FRAC_BITS fraction bits, truncating
   function automatic logic [FRAC_BITS-1:0] level_rescale(input logic [LEVEL_BITS-1:0] l);
      logic [LEVEL_BITS+FRAC_BITS-1:0] w;
      w = {l, {FRAC_BITS{1'b0}}};
      return w[LEVEL_BITS+FRAC_BITS-1:LEVEL_BITS];
   endfunction

endpackage

### src/adwv_drive.sv
// Drive gain stage: sample times drive gain, rounded half up, two stages.
// Depends on adwv_pkg.
module adwv_drive
   import adwv_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic [GAIN_BITS-1:0]          drive_gain,
   input  tag_type                       in_tag,
   input  logic signed [SAMPLE_BITS-1:0] in_sample,
   output tag_type                       out_tag,
   output logic signed [DRV_BITS-1:0]    out_drv
);

   tag_type                      tag1_ff;
   tag_type                      tag2_ff;
   logic signed [DPROD_BITS-1:0] prod_in;
   logic signed [DPROD_BITS-1:0] prod_ff;
   logic [DPROD_BITS-1:0]        rnd;
   logic signed [DRV_BITS-1:0]   drv_in;
   logic signed [DRV_BITS-1:0]   drv_ff;

   assign prod_in = in_sample * $signed({1'b0, drive_gain});

   // floor of (p + half) / 2^12 is the upper slice
   assign rnd    = prod_ff + DRV_HALF;
   assign drv_in = $signed(rnd[GAIN_FRAC+DRV_BITS-1:GAIN_FRAC]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      drv_ff  <= drv_in;
   end

   assign out_tag = tag2_ff;
   assign out_drv = drv_ff;

endmodule

### src/adwv_shape.sv
// Shaping pipeline: magnitude, hard/soft/exp/rectify lanes, mode select.
// Six register stages; depends on adwv_pkg (config struct, exp tables).
module adwv_shape
   import adwv_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  tag_type                    in_tag,
   input  logic signed [DRV_BITS-1:0] in_drv,
   output tag_type                    out_tag,
   output logic signed [DRV_BITS-1:0] out_y
);

   typedef struct packed {
      tag_type               tag;
      logic                  neg;
      logic [DRV_BITS-1:0]   drv;
      logic [MAG_BITS-1:0]   mag;
      logic [MAG_BITS-1:0]   hard;
      logic                  knee_low;    // 2a <= L
      logic                  knee_high;   // a > L
   } lane_type;

   logic [FRAC_BITS-1:0]            lvl;
   lane_type                        c1_in, c1_ff;
   lane_type                        c2_in, c2_ff;
   lane_type                        c3_ff, c4_ff, c5_ff;
   logic [DRV_BITS-1:0]             neg_drv;

   // soft lane
   logic [RECIP_BITS+FRAC_BITS-1:0] recip_prod;
   logic [T_BITS-1:0]               t2_in, t2_ff;
   logic [T_BITS-1:0]               knee_diff;
   logic [ONE_BITS-1:0]             d3_in, d3_ff;
   logic [2*ONE_BITS-1:0]           sq_prod;
   logic [ONE_BITS-1:0]             sq4_ff;
   logic [ONE_BITS-1:0]             one_minus_l;
   logic [2*ONE_BITS-1:0]           p_prod;
   logic [ONE_BITS-1:0]             p5_ff;

   // exp lane
   logic [EXP_S_BITS-1:0]           exp_s;
   logic [EXP_IDX_BITS-1:0]         hi2_in, hi2_ff;
   logic                            over2_in, over2_ff;
   logic [EXP_FR_BITS-1:0]          fr2_ff, fr3_ff;
   logic [EXP_Q:0]                  base3_in, base3_ff, base4_ff;
   logic [EXP_Q-1:0]                diff3_in, diff3_ff;
   logic [EXP_Q+EXP_FR_BITS-1:0]    ep_prod;
   logic [EXP_Q-1:0]                ep4_ff;
   logic [EXP_Q:0]                  exp_e;
   logic [EXP_Q:0]                  exp_om;
   logic [EXP_Q+FRAC_BITS:0]        exp_w;
   logic [FRAC_BITS-1:0]            emag5_ff;

   // select
   logic [ONE_BITS-1:0]             soft_half;
   logic signed [DRV_BITS-1:0]      y_in, y_ff;
   tag_type                         tag6_ff;

   assign lvl = level_rescale(cfg.clip_level);

   // stage 1: sign and magnitude
   assign neg_drv = -in_drv;
   always_comb begin
      c1_in           = '0;
      c1_in.tag       = in_tag;
      c1_in.neg       = in_drv[DRV_BITS-1];
      c1_in.drv       = in_drv;
      c1_in.mag       = in_drv[DRV_BITS-1] ? neg_drv[MAG_BITS-1:0] : in_drv[MAG_BITS-1:0];
   end

   // stage 2: knee flags, hard clip, recip product, table index
   always_comb begin
      c2_in           = c1_ff;
      c2_in.knee_low  = {c1_ff.mag, 1'b0} <= (MAG_BITS+1)'(lvl);
      c2_in.knee_high = c1_ff.mag > MAG_BITS'(lvl);
      c2_in.hard      = c2_in.knee_high ? MAG_BITS'(lvl) : c1_ff.mag;
   end

   // only the knee uses t, and there a <= L < 1
   assign recip_prod = c1_ff.mag[FRAC_BITS-1:0] * cfg.clip_recip;
   assign t2_in      = recip_prod[RECIP_BITS+FRAC_BITS-1:RECIP_FRAC];

   assign exp_s    = EXP_S_BITS'(c1_ff.mag) * EXP_S_BITS'(EXP_TABLE_ENTRIES);
   assign hi2_in   = exp_s[EXP_S_BITS-1:FRAC_BITS+EXP_RANGE_LOG2];
   assign over2_in = {1'b0, hi2_in} >= (EXP_IDX_BITS+1)'(EXP_TABLE_ENTRIES);

   // stage 3: d = clamp(2 - t, 0, 1); table read
   assign knee_diff = T_BITS'({ONE_Q, 1'b0}) - t2_ff;
   always_comb begin
      priority if (t2_ff >= T_BITS'({ONE_Q, 1'b0})) begin
         d3_in = '0;
      end else if (t2_ff <= T_BITS'(ONE_Q)) begin
         d3_in = ONE_Q;
      end else begin
         d3_in = knee_diff[ONE_BITS-1:0];
      end
   end

   // beyond the table: last entry, no slope
   assign base3_in = over2_ff ? EXP_LAST : EXP_BASE[hi2_ff];
   assign diff3_in = over2_ff ? '0 : EXP_DIFF[hi2_ff];

   // stage 4: d squared; slope times fraction
   assign sq_prod = d3_ff * d3_ff;
   assign ep_prod = diff3_ff * fr3_ff;

   // stage 5: s*(1-L); e and 1-e
   assign one_minus_l = ONE_Q - {1'b0, lvl};
   assign p_prod      = sq4_ff * one_minus_l;
   assign exp_e       = base4_ff - {1'b0, ep4_ff};
   assign exp_om      = EXP_ONE - exp_e;
   assign exp_w       = {exp_om, {FRAC_BITS{1'b0}}};

   // stage 6: pick the shape, restore sign
   assign soft_half = ONE_Q - p5_ff;
   always_comb begin
      logic [MAG_BITS-1:0] m;
      logic [DRV_BITS-1:0] sm;
      m = c5_ff.mag;
      unique case (cfg.mode)
         MODE_HARD: m = c5_ff.hard;
         MODE_SOFT: begin
            priority if (c5_ff.knee_low) begin
               m = c5_ff.mag;
            end else if (c5_ff.knee_high) begin
               m = HALF_MAG;
            end else begin
               m = MAG_BITS'(soft_half[ONE_BITS-1:1]);
            end
         end
         MODE_EXP:  m = MAG_BITS'(emag5_ff);
         default:   m = c5_ff.mag;
      endcase
      sm = c5_ff.neg ? -{1'b0, m} : {1'b0, m};
      unique case (cfg.mode)
         MODE_HARD, MODE_SOFT, MODE_EXP: y_in = $signed(sm);
         MODE_FULL: y_in = $signed({1'b0, c5_ff.mag});
         MODE_HALF: y_in = c5_ff.neg ? '0 : $signed(c5_ff.drv);
         default:   y_in = $signed(c5_ff.drv);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff   <= '0;
         c2_ff   <= '0;
         c3_ff   <= '0;
         c4_ff   <= '0;
         c5_ff   <= '0;
         tag6_ff <= '0;
      end else begin
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         c3_ff   <= c2_ff;
         c4_ff   <= c3_ff;
         c5_ff   <= c4_ff;
         tag6_ff <= c5_ff.tag;
      end
   end

   always_ff @(posedge clock) begin
      t2_ff    <= t2_in;
      hi2_ff   <= hi2_in;
      over2_ff <= over2_in;
      fr2_ff   <= exp_s[FRAC_BITS+EXP_RANGE_LOG2-1 -: EXP_FR_BITS];
      d3_ff    <= d3_in;
      base3_ff <= base3_in;
      diff3_ff <= diff3_in;
      fr3_ff   <= fr2_ff;
      sq4_ff   <= sq_prod[2*FRAC_BITS:FRAC_BITS];
      ep4_ff   <= ep_prod[EXP_Q+EXP_FR_BITS-1:EXP_FR_BITS];
      base4_ff <= base3_ff;
      p5_ff    <= p_prod[2*FRAC_BITS:FRAC_BITS];
      emag5_ff <= exp_w[EXP_Q+FRAC_BITS-1:EXP_Q];
      y_ff     <= y_in;
   end

   assign out_tag = tag6_ff;
   assign out_y   = y_ff;

endmodule

### src/adwv_outgain.sv
// Output gain stage: multiply, round half up, saturate to sample width.
// Depends on adwv_pkg.
module adwv_outgain
   import adwv_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic [GAIN_BITS-1:0]          output_gain,
   input  tag_type                       in_tag,
   input  logic signed [DRV_BITS-1:0]    in_y,
   output tag_type                       out_tag,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   tag_type                        tag1_ff;
   tag_type                        tag2_ff;
   logic signed [OPROD_BITS-1:0]   prod_in;
   logic signed [OPROD_BITS-1:0]   prod_ff;
   logic [OPROD_BITS-1:0]          rnd;
   logic [ORND_BITS-1:0]           r;
   logic                           fits;
   logic signed [SAMPLE_BITS-1:0]  sample_in;
   logic signed [SAMPLE_BITS-1:0]  sample_ff;

   assign prod_in = in_y * $signed({1'b0, output_gain});
   assign rnd     = prod_ff + OUT_HALF;
   assign r       = rnd[OPROD_BITS-1:GAIN_FRAC];

   // in range when the bits above the sample's sign agree with it
   assign fits = (&r[ORND_BITS-1:FRAC_BITS]) || !(|r[ORND_BITS-1:FRAC_BITS]);

   always_comb begin
      priority if (fits) begin
         sample_in = $signed(r[SAMPLE_BITS-1:0]);
      end else if (r[ORND_BITS-1]) begin
         sample_in = $signed({1'b1, {FRAC_BITS{1'b0}}});
      end else begin
         sample_in = $signed({1'b0, {FRAC_BITS{1'b1}}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      sample_ff <= sample_in;
   end

   assign out_tag    = tag2_ff;
   assign out_sample = sample_ff;

endmodule

### src/audio_distortion_waveshaper_core.sv
// Waveshaper core: accepts one sample per clock outside reset; each accepted sample gives one result strobe.
// The pipe has 2 drive, 6 shaping and 2 output gain stages.
// Throughput one sample per cycle; busy is high only during reset.
// Synchronous active-high reset clears all valid bits and loads the default
// register values; results cannot be stalled by the receiver.
// Depends on adwv_pkg, adwv_drive, adwv_shape, adwv_outgain.
module audio_distortion_waveshaper_core
   import adwv_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_block_end_in,
   output logic                          rsp_strobe,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_block_end_out,
   input  logic                          csr_we,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   cfg_type                     cfg_in;
   cfg_type                     cfg_ff;
   tag_type                     in_tag;
   tag_type                     drv_tag;
   tag_type                     shp_tag;
   tag_type                     out_tag;
   logic signed [DRV_BITS-1:0]  drv_val;
   logic signed [DRV_BITS-1:0]  shp_val;

   // The pipe has no stall path, so the only time a transfer is refused
   // is while reset holds the valid chain clear.
   assign busy = reset;

   // Register file. Writes to unused indexes fall through and are dropped.
   // Software must write only while no sample is in flight (the block does not
   // enforce this), so the stages read the live values without a shadow copy.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:   cfg_in.mode        = mode_type'(csr_wdata[MODE_BITS-1:0]);
            CSR_DRIVE:  cfg_in.drive_gain  = csr_wdata[GAIN_BITS-1:0];
            CSR_OUTPUT: cfg_in.output_gain = csr_wdata[GAIN_BITS-1:0];
            CSR_LEVEL:  cfg_in.clip_level  = csr_wdata[LEVEL_BITS-1:0];
            CSR_RECIP:  cfg_in.clip_recip  = csr_wdata[RECIP_BITS-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // valid and block-end marker travel together down the pipe
   assign in_tag = '{valid: start && !busy, block_end: req_block_end_in};

   // two stages: x * drive, then round
   adwv_drive u_drive (
      .clock      (clock),
      .reset      (reset),
      .drive_gain (cfg_ff.drive_gain),
      .in_tag     (in_tag),
      .in_sample  (req_sample_in),
      .out_tag    (drv_tag),
      .out_drv    (drv_val)
   );

   // six stages: abs, knee/index, clamp/table, squares, products, select
   adwv_shape u_shape (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .in_tag  (drv_tag),
      .in_drv  (drv_val),
      .out_tag (shp_tag),
      .out_y   (shp_val)
   );

   // two stages: y * output gain, then round and saturate
   adwv_outgain u_outgain (
      .clock       (clock),
      .reset       (reset),
      .output_gain (cfg_ff.output_gain),
      .in_tag      (shp_tag),
      .in_y        (shp_val),
      .out_tag     (out_tag),
      .out_sample  (rsp_sample_out)
   );

   assign rsp_strobe        = out_tag.valid;
   assign rsp_block_end_out = out_tag.block_end;

endmodule

### src/adwv_checker.sv
// Port-level checks for the waveshaper core, bound to the top level.
// Depends on adwv_pkg and audio_distortion_waveshaper_core_macros.svh.
`include "audio_distortion_waveshaper_core_macros.svh"

module adwv_checker
   import adwv_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_block_end_in,
   input  logic                          rsp_strobe,
   input  logic                          rsp_block_end_out
);

   // every input transfer produces a result strobe at the end of the pipe
   `ADWV_ASSERT(a_latency, clock, reset, (start && !busy) |-> ##PIPE_LATENCY rsp_strobe, "missing result strobe")

   // no strobe without a matching input transfer
   `ADWV_ASSERT(a_no_extra, clock, reset, rsp_strobe |-> $past(start && !busy, PIPE_LATENCY), "result strobe without transfer")

   // block-end marker stays with its sample
   `ADWV_ASSERT(a_block_end, clock, reset, (start && !busy) |-> ##PIPE_LATENCY (rsp_block_end_out == $past(req_block_end_in, PIPE_LATENCY)), "block end marker mismatch")

   // pipe comes out of reset empty
   `ADWV_ASSERT_ALWAYS(a_reset_clear, clock, $fell(reset) |-> !rsp_strobe, "strobe right after reset")

endmodule

bind audio_distortion_waveshaper_core adwv_checker u_adwv_checker (.*);
